>>> sv/edf_preemptive_scheduler_unit_macros.svh
// Assertion macros used by the scheduler back end.
`ifndef EDF_PREEMPTIVE_SCHEDULER_UNIT_MACROS_SVH
`define EDF_PREEMPTIVE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked while not in reset.
`define EDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while not in reset.
`define EDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/edf_pkg.sv
// Types, codes and helper functions of the EDF scheduler.
package edf_pkg;

   // Operation carried by one input item.
   typedef enum logic {
      OP_ARRIVE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   // Record kinds on the result channel.
   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_RESUME = 3'd1,
      KIND_SWITCH = 3'd2,
      KIND_IDLE   = 3'd3,
      KIND_FULL   = 3'd4
   } kind_type;

   // Engine states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_RESCAN,
      ST_FIN,
      ST_OUT
   } state_type;

   // One classified item as queued between front and back.
   typedef struct packed {
      op_type      op;
      logic [3:0]  task_id;
      logic [15:0] work;
      logic [31:0] deadline;
      logic        next_arrival;
   } item_type;

   // One stored job.
   typedef struct packed {
      logic [31:0] deadline;
      logic [3:0]  task_id;
      logic [15:0] remaining;
      logic [15:0] instance_num;
      logic [15:0] order;
   } slot_word_type;

   // One result record.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] rec_time;
      logic [3:0]  task_id;
      logic [15:0] instance_num;
   } rec_type;

   // True when job a outranks job b: earlier deadline, then lower task,
   // then earlier arrival compared modulo 2^16.
   function automatic logic outranks(input slot_word_type a, input slot_word_type b);
      logic [15:0] order_gap;
      order_gap = b.order - a.order;
      if (a.deadline != b.deadline) begin
         return a.deadline < b.deadline;
      end else if (a.task_id != b.task_id) begin
         return a.task_id < b.task_id;
      end else begin
         return !order_gap[15];
      end
   endfunction

endpackage

>>> sv/edf_front.sv
// Front end: accepts items, classifies them and queues them for the engine.
module edf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [3:0]         req_task_number,
   input  logic [15:0]        req_work_units,
   input  logic [31:0]        req_job_deadline,
   input  logic               req_arrival_next_unit,
   output logic               q_valid,
   output edf_pkg::item_type  q_item,
   input  logic               q_ready
);
   import edf_pkg::*;

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   item_cls;

   // Classify the incoming item: decode the operation, zero work runs as one.
   always_comb begin
      item_cls.op           = req_operation ? OP_TICK : OP_ARRIVE;
      item_cls.task_id      = req_task_number;
      item_cls.work         = (req_work_units == 16'd0) ? 16'd1 : req_work_units;
      item_cls.deadline     = req_job_deadline;
      item_cls.next_arrival = req_arrival_next_unit;
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_cls;
      end
   end

endmodule

>>> sv/edf_back.sv
// Back end: job table, deadline scan, scheduling decision and record output.
module edf_back #(
   parameter int MAX_JOBS  = 16,
   parameter int MAX_TASKS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               q_valid,
   input  edf_pkg::item_type  q_item,
   output logic               q_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output edf_pkg::rec_type   rsp_rec,
   output logic               rsp_last
);
   import edf_pkg::*;
   `include "edf_preemptive_scheduler_unit_macros.svh"

   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int SLOT_W = $clog2(MAX_JOBS + 1);
   localparam int TIDX_W = $clog2(MAX_TASKS);
   localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(MAX_JOBS);
   localparam logic [IDX_W:0]    SCAN_END = (IDX_W + 1)'(MAX_JOBS);

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic [7:0] ovh_ff;

   logic [MAX_JOBS-1:0] valid_ff, valid_in;
   logic [MAX_JOBS-1:0] started_ff, started_in;
   logic [MAX_JOBS-1:0] preempt_ff, preempt_in;
   logic [15:0] arr_cnt_ff, arr_cnt_in;
   logic [31:0] time_ff, time_in;
   logic [SLOT_W-1:0] running_ff, running_in;
   logic [15:0] swc_ff, swc_in;
   logic [15:0] idlec_ff, idlec_in;

   logic [IDX_W:0]   scan_idx_ff, scan_idx_in;
   logic             scan_pend_ff, scan_pend_in;
   logic [IDX_W-1:0] scan_j_ff, scan_j_in;
   logic             have_best_ff, have_best_in;
   logic [IDX_W-1:0] best_ff, best_in;
   slot_word_type    best_word_ff, best_word_in;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_ff, free_in;

   rec_type    rec_ff [2];
   rec_type    rec_in [2];
   logic [1:0] rec_cnt_ff, rec_cnt_in;
   logic       rec_ptr_ff, rec_ptr_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rec_type rsp_rec_ff, rsp_rec_in;
   logic    rsp_last_ff, rsp_last_in;

   // Job table memory.
   slot_word_type    slot_mem [MAX_JOBS];
   slot_word_type    slot_rd_ff;
   logic [IDX_W-1:0] slot_ra;
   logic             slot_we;
   logic [IDX_W-1:0] slot_wa;
   slot_word_type    slot_wd;

   // Per-task instance counter memory; an entry never written reads as one.
   logic [15:0]         tin_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0] tin_set_ff, tin_set_in;
   logic [15:0]         tin_rd_ff;
   logic                tin_set_rd_ff;
   logic [TIDX_W-1:0]   tin_ra;
   logic                tin_we;
   logic [15:0]         tin_wd;

   logic              scan_done, pop, out_free;
   logic [SLOT_W-1:0] best_ext, run_sel;
   logic              run_valid, do_switch, job_done;

   // Task number reduced modulo the task count by repeated subtraction.
   function automatic logic [3:0] task_mod(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (9'(r) >= 9'(MAX_TASKS)) begin
            r = 4'(9'(r) - 9'(MAX_TASKS));
         end
      end
      return r;
   endfunction

   logic [8:0] tmod9;
   assign tmod9  = {5'b0, task_mod(best_word_ff.task_id)};
   assign tin_ra = tmod9[TIDX_W-1:0];

   // Shared decision terms.
   assign scan_done = (scan_idx_ff == SCAN_END) && !scan_pend_ff;
   assign pop       = (state_ff == ST_IDLE) && q_valid;
   assign q_ready   = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign best_ext  = SLOT_W'(best_ff);
   assign run_sel   = (running_ff == NO_SLOT) ? best_ext : running_ff;
   assign run_valid = (run_sel != NO_SLOT) && valid_ff[run_sel[IDX_W-1:0]];
   assign do_switch = (run_sel != best_ext) && run_valid;
   assign job_done  = (best_word_ff.remaining == 16'd1);
   assign slot_ra   = scan_idx_ff[IDX_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (item_ff.op == OP_TICK && have_best_ff && !do_switch && job_done) begin
               state_in = ST_RESCAN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RESCAN: begin
            if (scan_done) state_in = ST_FIN;
         end
         ST_FIN: state_in = ST_OUT;
         ST_OUT: begin
            if (rec_cnt_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else if (out_free && ({1'b0, rec_ptr_ff} + 2'd1 == rec_cnt_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic [1:0]  k_v;
      logic [15:0] inst_v;
      item_in      = item_ff;
      valid_in     = valid_ff;
      started_in   = started_ff;
      preempt_in   = preempt_ff;
      arr_cnt_in   = arr_cnt_ff;
      time_in      = time_ff;
      running_in   = running_ff;
      swc_in       = swc_ff;
      idlec_in     = idlec_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pend_in = scan_pend_ff;
      scan_j_in    = scan_j_ff;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      best_word_in = best_word_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      rec_in[0]    = rec_ff[0];
      rec_in[1]    = rec_ff[1];
      rec_cnt_in   = rec_cnt_ff;
      rec_ptr_in   = rec_ptr_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      slot_we      = 1'b0;
      slot_wa      = best_ff;
      slot_wd      = best_word_ff;
      tin_we       = 1'b0;
      tin_wd       = 16'd0;
      tin_set_in   = tin_set_ff;
      k_v          = 2'd0;
      inst_v       = 16'd0;

      case (state_ff)
         ST_IDLE: begin
            // Take the next item and start a scan of the table.
            if (pop) begin
               item_in      = q_item;
               scan_idx_in  = '0;
               scan_pend_in = 1'b0;
               have_best_in = 1'b0;
               have_free_in = 1'b0;
            end
         end
         ST_SCAN, ST_RESCAN: begin
            // Issue one read per cycle and fold in the data of the last one.
            if (scan_idx_ff != SCAN_END) begin
               scan_idx_in  = scan_idx_ff + 1'b1;
               scan_pend_in = 1'b1;
               scan_j_in    = scan_idx_ff[IDX_W-1:0];
            end else begin
               scan_pend_in = 1'b0;
            end
            if (scan_pend_ff) begin
               if (valid_ff[scan_j_ff]) begin
                  if (!have_best_ff || outranks(slot_rd_ff, best_word_ff)) begin
                     have_best_in = 1'b1;
                     best_in      = scan_j_ff;
                     best_word_in = slot_rd_ff;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = scan_j_ff;
               end
            end
         end
         ST_EXEC: begin
            rec_ptr_in = 1'b0;
            if (item_ff.op == OP_ARRIVE) begin
               // Store the job in the lowest free slot, or report a full table.
               if (!have_free_ff) begin
                  rec_in[0] = '{KIND_FULL, time_ff, 4'd0, 16'd0};
                  k_v       = 2'd1;
               end else begin
                  slot_we             = 1'b1;
                  slot_wa             = free_ff;
                  slot_wd             = '{item_ff.deadline, item_ff.task_id, item_ff.work,
                                          16'd0, arr_cnt_ff};
                  valid_in[free_ff]   = 1'b1;
                  started_in[free_ff] = 1'b0;
                  preempt_in[free_ff] = 1'b0;
                  arr_cnt_in          = arr_cnt_ff + 16'd1;
               end
            end else if (!have_best_ff) begin
               // Empty table: time moves on with nothing running.
               running_in = NO_SLOT;
               time_in    = time_ff + 32'd1;
            end else begin
               // A preempted job coming back resumes if it had started.
               if (preempt_ff[best_ff]) begin
                  preempt_in[best_ff] = 1'b0;
                  if (started_ff[best_ff]) begin
                     rec_in[0] = '{KIND_RESUME, time_ff, best_word_ff.task_id,
                                   best_word_ff.instance_num};
                     k_v       = 2'd1;
                  end
               end
               if (do_switch) begin
                  // Switch away from the running job.
                  if (ovh_ff != 8'd0) begin
                     rec_in[k_v[0]] = '{KIND_SWITCH, time_ff, 4'd0, swc_ff};
                     k_v            = k_v + 2'd1;
                     time_in        = time_ff + {24'd0, ovh_ff};
                  end
                  swc_in                            = swc_ff + 16'd1;
                  preempt_in[run_sel[IDX_W-1:0]]    = 1'b1;
                  running_in                        = best_ext;
               end else begin
                  // Run the best job for one time unit.
                  inst_v = best_word_ff.instance_num;
                  if (!started_ff[best_ff]) begin
                     inst_v              = tin_set_rd_ff ? tin_rd_ff : 16'd1;
                     rec_in[k_v[0]]      = '{KIND_START, time_ff, best_word_ff.task_id, inst_v};
                     k_v                 = k_v + 2'd1;
                     tin_we              = 1'b1;
                     tin_wd              = inst_v + 16'd1;
                     tin_set_in[tin_ra]  = 1'b1;
                     started_in[best_ff] = 1'b1;
                  end
                  slot_we              = 1'b1;
                  slot_wa              = best_ff;
                  slot_wd              = best_word_ff;
                  slot_wd.remaining    = best_word_ff.remaining - 16'd1;
                  slot_wd.instance_num = inst_v;
                  time_in              = time_ff + 32'd1;
                  if (job_done) begin
                     valid_in[best_ff]   = 1'b0;
                     preempt_in[best_ff] = 1'b0;
                     scan_idx_in         = '0;
                     scan_pend_in        = 1'b0;
                     have_best_in        = 1'b0;
                     have_free_in        = 1'b0;
                  end else begin
                     running_in = best_ext;
                  end
               end
            end
            rec_cnt_in = k_v;
         end
         ST_FIN: begin
            // After a job finishes: pick the next runner and maybe report idle.
            running_in = have_best_ff ? best_ext : NO_SLOT;
            if (!have_best_ff && !item_ff.next_arrival) begin
               rec_in[rec_cnt_ff[0]] = '{KIND_IDLE, time_ff, 4'd0, idlec_ff};
               rec_cnt_in            = rec_cnt_ff + 2'd1;
               idlec_in              = idlec_ff + 16'd1;
            end
         end
         ST_OUT: begin
            // Hand records to the output register one per transfer.
            if (rec_cnt_ff != 2'd0 && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = rec_ff[rec_ptr_ff];
               rsp_last_in  = ({1'b0, rec_ptr_ff} + 2'd1 == rec_cnt_ff);
               rec_ptr_in   = !rec_ptr_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_rec_ff;
   assign rsp_last  = rsp_last_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ovh_ff       <= 8'd0;
         valid_ff     <= '0;
         started_ff   <= '0;
         preempt_ff   <= '0;
         arr_cnt_ff   <= 16'd0;
         time_ff      <= 32'd0;
         running_ff   <= NO_SLOT;
         swc_ff       <= 16'd1;
         idlec_ff     <= 16'd1;
         tin_set_ff   <= '0;
         scan_idx_ff  <= '0;
         scan_pend_ff <= 1'b0;
         have_best_ff <= 1'b0;
         have_free_ff <= 1'b0;
         rec_cnt_ff   <= 2'd0;
         rec_ptr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) ovh_ff <= csr_wr_data;
         valid_ff     <= valid_in;
         started_ff   <= started_in;
         preempt_ff   <= preempt_in;
         arr_cnt_ff   <= arr_cnt_in;
         time_ff      <= time_in;
         running_ff   <= running_in;
         swc_ff       <= swc_in;
         idlec_ff     <= idlec_in;
         tin_set_ff   <= tin_set_in;
         scan_idx_ff  <= scan_idx_in;
         scan_pend_ff <= scan_pend_in;
         have_best_ff <= have_best_in;
         have_free_ff <= have_free_in;
         rec_cnt_ff   <= rec_cnt_in;
         rec_ptr_ff   <= rec_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      scan_j_ff    <= scan_j_in;
      best_ff      <= best_in;
      best_word_ff <= best_word_in;
      free_ff      <= free_in;
      rec_ff[0]    <= rec_in[0];
      rec_ff[1]    <= rec_in[1];
      rsp_rec_ff   <= rsp_rec_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Job table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ra];
   end

   // Instance counters: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tin_we) tin_mem[tin_ra] <= tin_wd;
      tin_rd_ff     <= tin_mem[tin_ra];
      tin_set_rd_ff <= tin_set_ff[tin_ra];
   end

   // While idle, the running job is a live table entry or none.
   `EDF_ASSERT_NOW(a_running_live, clock, reset, state_ff == ST_IDLE, (running_ff == NO_SLOT) || valid_ff[running_ff[IDX_W-1:0]], "running slot is not a live job")
   // A tick only acts on a live job.
   `EDF_ASSERT_NOW(a_best_live, clock, reset, (state_ff == ST_EXEC) && (item_ff.op == OP_TICK) && have_best_ff, valid_ff[best_ff], "chosen job is not live")
   // An item never causes more than two records.
   `EDF_ASSERT_NOW(a_rec_bound, clock, reset, state_ff == ST_OUT, rec_cnt_ff != 2'd3, "too many records for one item")
   // A finished job is followed by a rescan of the table.
   `EDF_ASSERT_NEXT(a_rescan_start, clock, reset, (state_ff == ST_EXEC) && (state_in == ST_RESCAN), (scan_idx_ff == '0) && !have_best_ff, "rescan did not restart")

endmodule

>>> sv/edf_preemptive_scheduler_unit.sv
// Top level of the preemptive earliest-deadline-first scheduler.
// The engine takes an item from its queue, then walks the job table through its single
// read port, one slot a cycle, and makes one scheduling decision; records then leave one a
// cycle while the output register is free, and an item that causes no record returns the
// engine straight to idle. A tick that finishes a job walks the table a second time and
// then chooses the next runner. Items are queued two deep ahead of the engine and records
// leave through an output register, so the input keeps taking items while a record waits.
// switch_overhead is written through csr_wr_en/csr_wr_data and must only change while idle.
module edf_preemptive_scheduler_unit #(
   parameter int MAX_JOBS  = 16,
   parameter int MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [3:0]  req_task_number,
   input  logic [15:0] req_work_units,
   input  logic [31:0] req_job_deadline,
   input  logic        req_arrival_next_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_record_kind,
   output logic [31:0] rsp_record_time,
   output logic [3:0]  rsp_record_task,
   output logic [15:0] rsp_record_instance,
   output logic        rsp_last_record
);
   import edf_pkg::*;

   logic     q_valid, q_ready;
   item_type q_item;
   rec_type  rsp_rec;

   edf_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_task_number       (req_task_number),
      .req_work_units        (req_work_units),
      .req_job_deadline      (req_job_deadline),
      .req_arrival_next_unit (req_arrival_next_unit),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .q_ready               (q_ready)
   );

   edf_back #(
      .MAX_JOBS  (MAX_JOBS),
      .MAX_TASKS (MAX_TASKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_ready     (q_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_rec     (rsp_rec),
      .rsp_last    (rsp_last_record)
   );

   // Split the record into its output fields.
   assign rsp_record_kind     = 3'(rsp_rec.kind);
   assign rsp_record_time     = rsp_rec.rec_time;
   assign rsp_record_task     = rsp_rec.task_id;
   assign rsp_record_instance = rsp_rec.instance_num;

endmodule
